### sv/espa_pkg.sv
package espa_pkg;

   // default pool size
   localparam int SLOTS_DEFAULT = 256;

   // field widths
   localparam int MODE_W  = 2;
   localparam int LIFE_W  = 16;
   localparam int SLOT_W  = 8;
   localparam int COUNT_W = 9;

   // stream payload widths
   localparam int REQ_TDATA_W = 2 * LIFE_W;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_PAD_W   = RSP_TDATA_W - SLOT_W - 1 - COUNT_W;

   // request modes
   localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   // one pool entry as held in the slot memory
   typedef struct packed {
      logic              active;
      logic [LIFE_W-1:0] life;
   } entry_type;

endpackage

### sv/espa_ram.sv
module espa_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/expiring_slot_pool_allocator_core.sv
// expiring slot pool allocator
//
// req channel: one transaction per request; req_tuser carries the mode
// (allocate, tick, clear), req_tdata the lifetime and the elapsed ticks.
// rsp channel: exactly one transaction per request, in request order,
// carrying slot index, eviction flag and expired count.
//
// every slot (active mark and lifetime) lives in one single-port-read,
// single-port-write memory with a registered read. all work is a walk
// over that memory, one entry per cycle, so one request is handled at a
// time:
//   allocate  circular probe from the cursor
//   tick      read of every slot, write-back of the active ones
//   clear     zeroing sweep
//   unused    no change, all-zero result
// after reset a clearing pass zeroes the memory; req_tready stays low
// until it is done. the result sits in an output register, so a stalled
// receiver holds only the finishing step of the next request.
module expiring_slot_pool_allocator_core #(
   parameter int SLOTS = espa_pkg::SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [espa_pkg::REQ_TDATA_W-1:0] req_tdata,  // lifetime[15:0], elapsed[31:16]
   input  logic [espa_pkg::MODE_W-1:0]     req_tuser,  // mode[1:0]
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [espa_pkg::RSP_TDATA_W-1:0] rsp_tdata   // slot_index[7:0], evicted[8],
                                                       // expired_count[17:9], zero[23:18]
);

   localparam int AW = $clog2(SLOTS);
   localparam int CW = AW + 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);
   localparam int EW = $bits(espa_pkg::entry_type);

   // sequencer states
   localparam logic [2:0] ST_INIT   = 3'd0;  // clearing pass after reset
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SEARCH = 3'd2;  // circular probe for a free slot
   localparam logic [2:0] ST_TICK   = 3'd3;  // lifetime walk
   localparam logic [2:0] ST_WIPE   = 3'd4;  // clear request sweep
   localparam logic [2:0] ST_DONE   = 3'd5;  // hand result to output register

   logic [2:0]                      state_ff, state_in;
   logic [AW-1:0]                   idx_ff, idx_in;        // entry whose read data arrives
   logic [AW-1:0]                   steps_ff, steps_in;    // probes already done in search
   logic [AW-1:0]                   cursor_ff, cursor_in;
   logic [espa_pkg::LIFE_W-1:0]     life_ff, life_in;
   logic [espa_pkg::LIFE_W-1:0]     dt_ff, dt_in;
   logic [AW-1:0]                   res_slot_ff, res_slot_in;
   logic                            res_ev_ff, res_ev_in;
   logic [CW-1:0]                   res_count_ff, res_count_in;
   logic                            rsp_tvalid_ff, rsp_tvalid_in;
   logic [espa_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // memory port signals
   logic                            wr_en;
   logic [AW-1:0]                   wr_addr;
   espa_pkg::entry_type             wr_entry;
   logic                            rd_en;
   logic [AW-1:0]                   rd_addr;
   logic [EW-1:0]                   rd_word;
   espa_pkg::entry_type             rd_entry;

   logic                            req_fire;
   logic                            out_free;
   logic [AW-1:0]                   idx_next;
   logic [AW-1:0]                   cursor_next;
   logic [espa_pkg::LIFE_W-1:0]     aged_life;
   logic [AW+espa_pkg::SLOT_W-1:0]  slot_wide;
   logic [CW+espa_pkg::COUNT_W-1:0] count_wide;

   espa_ram #(
      .WIDTH (EW),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_entry   = espa_pkg::entry_type'(rd_word);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // circular successors
   assign idx_next    = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
   assign cursor_next = (cursor_ff == LAST_IDX) ? '0 : cursor_ff + 1'b1;

   // saturating lifetime decrement
   assign aged_life = (rd_entry.life > dt_ff) ? rd_entry.life - dt_ff : '0;

   // result fields fitted to the stream widths
   assign slot_wide  = {{espa_pkg::SLOT_W{1'b0}}, res_slot_ff};
   assign count_wide = {{espa_pkg::COUNT_W{1'b0}}, res_count_ff};

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      steps_in      = steps_ff;
      cursor_in     = cursor_ff;
      life_in       = life_ff;
      dt_in         = dt_ff;
      res_slot_in   = res_slot_ff;
      res_ev_in     = res_ev_ff;
      res_count_in  = res_count_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_entry      = '0;
      rd_en         = 1'b0;
      rd_addr       = idx_next;

      unique case (state_ff)
         ST_INIT, ST_WIPE: begin
            // zero one entry per cycle
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_DONE;
            end else begin
               idx_in = idx_next;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               life_in      = req_tdata[espa_pkg::LIFE_W-1:0];
               dt_in        = req_tdata[espa_pkg::REQ_TDATA_W-1:espa_pkg::LIFE_W];
               res_slot_in  = '0;
               res_ev_in    = 1'b0;
               res_count_in = '0;
               unique case (req_tuser)
                  espa_pkg::MODE_ALLOC: begin
                     rd_en    = 1'b1;
                     rd_addr  = cursor_ff;
                     idx_in   = cursor_ff;
                     steps_in = '0;
                     state_in = ST_SEARCH;
                  end
                  espa_pkg::MODE_TICK: begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     idx_in   = '0;
                     state_in = ST_TICK;
                  end
                  espa_pkg::MODE_CLEAR: begin
                     idx_in    = '0;
                     cursor_in = '0;
                     state_in  = ST_WIPE;
                  end
                  default: begin
                     // unused mode: no change, all-zero result
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            priority if (!rd_entry.active) begin
               // free slot found
               wr_en           = 1'b1;
               wr_addr         = idx_ff;
               wr_entry.active = 1'b1;
               wr_entry.life   = life_ff;
               cursor_in       = idx_next;
               res_slot_in     = idx_ff;
               state_in        = ST_DONE;
            end else if (steps_ff == LAST_IDX) begin
               // pool full: evict the slot at the cursor
               wr_en           = 1'b1;
               wr_addr         = cursor_ff;
               wr_entry.active = 1'b1;
               wr_entry.life   = life_ff;
               cursor_in       = cursor_next;
               res_slot_in     = cursor_ff;
               res_ev_in       = 1'b1;
               state_in        = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_next;
               idx_in   = idx_next;
               steps_in = steps_ff + 1'b1;
            end
         end
         ST_TICK: begin
            // write back entry idx while entry idx + 1 is read
            if (rd_entry.active) begin
               wr_en           = 1'b1;
               wr_addr         = idx_ff;
               wr_entry.active = (aged_life != '0);
               wr_entry.life   = aged_life;
               if (aged_life == '0) begin
                  res_count_in = res_count_ff + CW'(1);
               end
            end
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_DONE;
            end else begin
               rd_en  = 1'b1;
               idx_in = idx_next;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {{espa_pkg::RSP_PAD_W{1'b0}},
                                count_wide[espa_pkg::COUNT_W-1:0],
                                res_ev_ff,
                                slot_wide[espa_pkg::SLOT_W-1:0]};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            idx_in   = '0;
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         idx_ff        <= '0;
         cursor_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         cursor_ff     <= cursor_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      steps_ff     <= steps_in;
      life_ff      <= life_in;
      dt_ff        <= dt_in;
      res_slot_ff  <= res_slot_in;
      res_ev_ff    <= res_ev_in;
      res_count_ff <= res_count_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // a result only appears from the finishing state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside finishing state");

   // an accepted request starts work at once
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("accepted request left sequencer idle");

   // a tick walk never moves the cursor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK) |=> $stable(cursor_ff))
      else $error("cursor moved during tick walk");

   // the expired count never exceeds the pool size
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (res_count_ff <= CW'(SLOTS)))
      else $error("expired count beyond pool size");

endmodule

### test/expiring_slot_pool_allocator_core_test.sv
module expiring_slot_pool_allocator_core_test;

   localparam int SLOTS = espa_pkg::SLOTS_DEFAULT;

   typedef logic [espa_pkg::MODE_W-1:0] mode_type;
   typedef logic [espa_pkg::LIFE_W-1:0] life_type;

   // mode 3 has no operation behind it: the block must answer with zeros
   localparam mode_type MODE_UNUSED = 2'd3;

   // nothing accepted on either channel for this long means the block hung;
   // worst honest stretch is the long receiver hold plus an op plus a long
   // sender gap, well below this
   localparam int STUCK_LIMIT = 8000;
   localparam int HOLD_CYCLES = 1500;
   localparam int RANDOM_ITEMS = 1300;

   typedef struct packed {
      mode_type mode;
      life_type lifetime;
      life_type elapsed;
   } pool_request_type;

   typedef struct packed {
      logic [espa_pkg::SLOT_W-1:0]  slot;
      logic                         evicted;
      logic [espa_pkg::COUNT_W-1:0] expired;
   } pool_response_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [espa_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   mode_type                         req_tuser = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [espa_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // requests still to be offered, and responses still owed by the block
   pool_request_type  request_q[$];
   pool_response_type due_responses[$];

   // shadow of the pool
   bit                pool_active[SLOTS];
   life_type          pool_life[SLOTS];
   int                pool_cursor;

   pool_request_type  offered_req;
   pool_response_type got_rsp;
   pool_response_type want_rsp;
   int             req_wait;
   int             rsp_wait;
   int             hold_left;
   int             rsp_seen;
   int             mismatches;
   int             stuck_cycles;
   int             calm_left[2];

   expiring_slot_pool_allocator_core #(
      .SLOTS(SLOTS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // pool behaviour, one request at a time, in acceptance order
   // ---------------------------------------------------------------------
   function automatic pool_response_type pool_apply(input pool_request_type r);
      pool_response_type res;
      int             i;
      int             idx;
      int             freed;
      bit             found;
      res   = '0;
      freed = 0;
      found = 1'b0;
      idx   = pool_cursor;
      case (r.mode)
         espa_pkg::MODE_ALLOC: begin
            // next fit from the cursor; with no free slot the cursor slot is taken
            for (i = 0; i < SLOTS; i++) begin
               if (!found && !pool_active[(pool_cursor + i) % SLOTS]) begin
                  found = 1'b1;
                  idx   = (pool_cursor + i) % SLOTS;
               end
            end
            pool_active[idx] = 1'b1;
            pool_life[idx]   = r.lifetime;
            pool_cursor      = (idx + 1) % SLOTS;
            res.slot         = idx[espa_pkg::SLOT_W-1:0];
            res.evicted      = !found;
         end
         espa_pkg::MODE_TICK: begin
            // saturating countdown, a slot at zero is released
            for (i = 0; i < SLOTS; i++) begin
               if (pool_active[i]) begin
                  if (pool_life[i] > r.elapsed)
                     pool_life[i] = pool_life[i] - r.elapsed;
                  else
                     pool_life[i] = '0;
                  if (pool_life[i] == '0) begin
                     pool_active[i] = 1'b0;
                     freed++;
                  end
               end
            end
            res.expired = freed[espa_pkg::COUNT_W-1:0];
         end
         espa_pkg::MODE_CLEAR: begin
            for (i = 0; i < SLOTS; i++) begin
               pool_active[i] = 1'b0;
               pool_life[i]   = '0;
            end
            pool_cursor = 0;
         end
         default: ;
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   task queue_request(input mode_type mode, input life_type lifetime,
                      input life_type elapsed);
      pool_request_type r;
      r.mode     = mode;
      r.lifetime = lifetime;
      r.elapsed  = elapsed;
      request_q.push_back(r);
   endtask

   // lifetimes spread over several magnitudes, small ones most often
   function automatic life_type draw_lifetime();
      life_type v;
      case ($urandom_range(0, 9))
         0, 1, 2: v = life_type'($urandom_range(0, 8));
         3, 4, 5: v = life_type'($urandom_range(0, 100));
         6, 7:    v = life_type'($urandom_range(0, 4000));
         default: v = life_type'($urandom_range(0, 65535));
      endcase
      return v;
   endfunction

   // elapsed ticks kept smaller so that slots live across several ticks
   function automatic life_type draw_elapsed();
      life_type v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = life_type'($urandom_range(0, 4));
         4, 5, 6:    v = life_type'($urandom_range(0, 40));
         7, 8:       v = life_type'($urandom_range(0, 2000));
         default:    v = life_type'($urandom_range(0, 65535));
      endcase
      return v;
   endfunction

   // idle length for one side (0 sender, 1 receiver): mostly short, a few
   // long enough to span a whole walk of the pool, with calm stretches
   function automatic int pick_gap(input int side);
      int roll;
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0)
         calm_left[side] = $urandom_range(10, 50);
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 96)
         return $urandom_range(4, 40);
      return $urandom_range(60, 400);
   endfunction

   task report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("mismatch at response %0d: %s got %0d expected %0d",
               rsp_seen, what, got, want);
   endtask

   // ---------------------------------------------------------------------
   // request driver: offers queued requests, idles between transactions
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_wait = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            due_responses.push_back(pool_apply(offered_req));
            req_wait = pick_gap(0);
         end
         // hold the offer while it is not taken
         if (!req_tvalid || req_tready) begin
            if (req_wait > 0 || request_q.size() == 0) begin
               if (req_wait > 0)
                  req_wait--;
               req_tvalid <= 1'b0;
            end else begin
               offered_req = request_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {offered_req.elapsed, offered_req.lifetime};
               req_tuser  <= offered_req.mode;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // response monitor and receiver back-pressure
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait  = 0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_rsp.slot    = rsp_tdata[espa_pkg::SLOT_W-1:0];
            got_rsp.evicted = rsp_tdata[espa_pkg::SLOT_W];
            got_rsp.expired = rsp_tdata[espa_pkg::SLOT_W+1 +: espa_pkg::COUNT_W];
            if (due_responses.size() == 0) begin
               report_mismatch("response with nothing outstanding, slot", got_rsp.slot, 0);
            end else begin
               want_rsp = due_responses.pop_front();
               if (got_rsp.slot !== want_rsp.slot)
                  report_mismatch("slot_index", got_rsp.slot, want_rsp.slot);
               if (got_rsp.evicted !== want_rsp.evicted)
                  report_mismatch("evicted", got_rsp.evicted, want_rsp.evicted);
               if (got_rsp.expired !== want_rsp.expired)
                  report_mismatch("expired_count", got_rsp.expired, want_rsp.expired);
            end
            rsp_seen++;
            rsp_wait = pick_gap(1);
            // long hold-off twice in the run: the block fills and stalls req
            if (rsp_seen == 40 || rsp_seen == 700)
               hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: counts cycles without any transaction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles == STUCK_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus, reset and end of run
   // ---------------------------------------------------------------------
   initial begin
      int       i;
      int       n;
      bit       first_fill;
      mode_type m;

      first_fill = 1'b1;
      pool_cursor = 0;
      for (i = 0; i < SLOTS; i++) begin
         pool_active[i] = 1'b0;
         pool_life[i]   = '0;
      end

      // directed: unused mode with every data bit set, then on an empty pool
      queue_request(MODE_UNUSED,          16'hFFFF, 16'hFFFF);
      queue_request(espa_pkg::MODE_TICK,  16'hFFFF, 16'h0000);
      // zero lifetime, top lifetime, a few small ones
      queue_request(espa_pkg::MODE_ALLOC, 16'h0000, 16'hFFFF);
      queue_request(espa_pkg::MODE_ALLOC, 16'hFFFF, 16'h0000);
      queue_request(espa_pkg::MODE_ALLOC, 16'h0005, 16'h1234);
      queue_request(espa_pkg::MODE_ALLOC, 16'h0001, 16'h0000);
      // zero elapsed releases only the zero-lifetime slot
      queue_request(espa_pkg::MODE_TICK,  16'h0000, 16'h0000);
      queue_request(espa_pkg::MODE_ALLOC, 16'h0007, 16'h0000);
      // countdown past zero must saturate, not wrap
      queue_request(espa_pkg::MODE_TICK,  16'hABCD, 16'h000A);
      queue_request(espa_pkg::MODE_TICK,  16'h0000, 16'hFFFF);
      queue_request(espa_pkg::MODE_ALLOC, 16'h0064, 16'h0000);
      queue_request(espa_pkg::MODE_ALLOC, 16'h8000, 16'h0000);
      queue_request(espa_pkg::MODE_TICK,  16'h0000, 16'h7FFF);
      queue_request(espa_pkg::MODE_TICK,  16'h0000, 16'h0001);
      // clear resets the cursor: next grant is slot zero again
      queue_request(espa_pkg::MODE_ALLOC, 16'h0003, 16'h0000);
      queue_request(espa_pkg::MODE_CLEAR, 16'h5A5A, 16'hA5A5);
      queue_request(espa_pkg::MODE_ALLOC, 16'h0003, 16'h0000);
      queue_request(MODE_UNUSED,          16'h0000, 16'h0000);
      queue_request(espa_pkg::MODE_TICK,  16'h0000, 16'h0003);
      queue_request(espa_pkg::MODE_CLEAR, 16'h0000, 16'h0000);

      // random part, built from segments
      while (request_q.size() < RANDOM_ITEMS + 20) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               // churn: allocations and ticks with the odd clear or unused mode
               for (i = 0; i < 30; i++) begin
                  n = $urandom_range(0, 99);
                  if (n < 55)
                     m = espa_pkg::MODE_ALLOC;
                  else if (n < 90)
                     m = espa_pkg::MODE_TICK;
                  else if (n < 93)
                     m = espa_pkg::MODE_CLEAR;
                  else
                     m = MODE_UNUSED;
                  queue_request(m, draw_lifetime(), draw_elapsed());
               end
            end
            5, 6, 7: begin
               // fill: runs of allocations, the first long enough to wrap the pool and
               // evict; the first always ends in a tick that releases every slot at once
               n = first_fill ? SLOTS + $urandom_range(1, 8) : $urandom_range(120, SLOTS + 12);
               for (i = 0; i < n; i++)
                  queue_request(espa_pkg::MODE_ALLOC, draw_lifetime(),
                                life_type'($urandom_range(0, 65535)));
               if (first_fill || $urandom_range(0, 1) == 0) begin
                  queue_request(espa_pkg::MODE_TICK, life_type'($urandom_range(0, 65535)),
                                16'hFFFF);
               end else begin
                  for (i = 0; i < $urandom_range(1, 4); i++)
                     queue_request(espa_pkg::MODE_TICK, life_type'($urandom_range(0, 65535)),
                                   draw_elapsed());
               end
               first_fill = 1'b0;
            end
            default: begin
               // noise: any mode, any field value
               for (i = 0; i < 10; i++)
                  queue_request(mode_type'($urandom_range(0, 3)),
                                life_type'($urandom_range(0, 65535)),
                                life_type'($urandom_range(0, 65535)));
            end
         endcase
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // drain: every request taken and every response back
      while (request_q.size() != 0 || req_tvalid || due_responses.size() != 0)
         @(posedge clock);
      // a stray extra response would show up within one walk of the pool
      repeat (2 * SLOTS + 16) @(posedge clock);

      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
